### sv/rcm_pkg.sv
// Shared constants and codes for the reverse Cuthill-McKee reorder block.
package rcm_pkg;

  localparam int KIND_W = 3;
  localparam int ROW_W  = 10;
  localparam int IDX_W  = 13;
  localparam int STAT_W = 2;
  localparam int VAL_W  = 13;
  localparam int BWID_W = 10;
  localparam int NV_W   = 11;

  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_MAX_EDGES    = 8192;

  localparam logic [NV_W-1:0]   NV_RESET  = 11'd1024;
  localparam logic [BWID_W-1:0] BWID_MAX  = 10'd1023;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RUN    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RD_VTX = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RD_EDG = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_NORD  = 2'd3;

endpackage

### sv/rcm_sparse_reorder.sv
// Reverse Cuthill-McKee reordering engine for a sparse matrix held in on-chip memories.
//
// A command word is taken at a clock edge where start is high and busy is low. Loads,
// clears and read-backs are done in the idle state and can be issued back to back; the result
// word appears with done high in the cycle after the command is taken. A run holds busy
// high while a sequencer walks the graph through memories with one write port and one
// registered read port each, and the result follows the last edge position write.
// A run clears the vertex tables, counts degrees, and per component picks an unvisited
// start vertex of least degree; it scans the edge store for the neighbours of each
// vertex taken from the BFS queue and insertion-sorts them by degree, then renumbers
// the edge keys, forms bucket prefix sums and runs two stable scatter passes.
// The neighbour scan reads the whole edge store for each vertex taken from the queue.
// The one register, num_vertices, is written over cfg_valid/cfg_ready while idle; it
// clears the ordered state. Reset empties the edge store, clears the ordered state and
// both bandwidth values, and sets num_vertices to 1024; no memory clearing pass is run.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module rcm_sparse_reorder #(
  parameter int MAX_VERTICES = rcm_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = rcm_pkg::DEF_MAX_EDGES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rcm_pkg::KIND_W-1:0]    kind,
  input  logic [rcm_pkg::ROW_W-1:0]     row,
  input  logic [rcm_pkg::ROW_W-1:0]     col,
  input  logic [rcm_pkg::IDX_W-1:0]     index,
  output logic                          done,
  output logic [rcm_pkg::STAT_W-1:0]    status,
  output logic [rcm_pkg::VAL_W-1:0]     value,
  output logic [rcm_pkg::BWID_W-1:0]    bandwidth_before,
  output logic [rcm_pkg::BWID_W-1:0]    bandwidth_after,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rcm_pkg::NV_W-1:0]      cfg_data
);
  import rcm_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int BW = $clog2(MAX_VERTICES + 1);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int CW = $clog2(MAX_EDGES + 1);

  typedef enum logic [5:0] {
    S_IDLE, S_CLR, S_DEG_RD, S_DEG_EV, S_DEG_WR,
    S_SEL_INIT, S_SEL_RD, S_SEL_EV, S_SEL_END,
    S_BFS_HEAD, S_BFS_Y, S_SCAN_RD, S_SCAN_EV, S_SCAN_VIS,
    S_INS_CHK, S_INS_EV, S_APP, S_APP_WR,
    S_KEY_RD, S_KEY_EV, S_KEY_C, S_KEY_D, S_KEY_WR, S_KEY_CNT,
    S_PFX, S_PFX_WR, S_S1_RD, S_S1_B, S_S1_WR,
    S_S2_RD, S_S2_B, S_S2_C, S_S2_WR, S_DONE
  } state_t;

  typedef enum logic [1:0] {SRC_REG, SRC_NIDX, SRC_EPOS} src_t;

  typedef struct packed {
    logic [CW-1:0] deg;
    logic [VW-1:0] vtx;
  } nbuf_ent_t;

  state_t state;
  src_t   src;

  logic [CW-1:0]     ecount;
  logic              ordered;
  logic [BWID_W-1:0] bw_before_r, bw_after_r;
  logic [NV_W-1:0]   nv;
  logic [NW-1:0]     n, n_cur;
  logic [NW:0]       v;
  logic [CW-1:0]     i;
  logic [NW-1:0]     head, tail, k;
  logic [VW-1:0]     j, y, s, cn, ck;
  logic [CW-1:0]     sdeg, nd, accc, accr;
  logic              sfound;
  logic [ROW_W-1:0]  er, ec;
  logic [NW-1:0]     rk, bwb, bwa, kdiff;
  logic [EW-1:0]     ee;
  logic              done_r;
  logic [STAT_W-1:0] status_r;
  logic [VAL_W-1:0]  value_r;
  logic              accept, in_rng;
  logic [ROW_W-1:0]  ediff;

  // Memory ports.
  logic [ROW_W-1:0] erow_mem [MAX_EDGES];
  logic [ROW_W-1:0] ecol_mem [MAX_EDGES];
  logic             e_we;
  logic [EW-1:0]    e_wa, e_ra;
  logic [ROW_W-1:0] erow_q, ecol_q;

  logic [CW-1:0] deg_mem [MAX_VERTICES];
  logic          deg_we;
  logic [VW-1:0] deg_wa, deg_ra;
  logic [CW-1:0] deg_wd, deg_q;

  logic          vis_mem [MAX_VERTICES];
  logic          vis_we, vis_wd, vis_q;
  logic [VW-1:0] vis_wa, vis_ra;

  logic [VW-1:0] queue_mem [MAX_VERTICES];
  logic          queue_we;
  logic [VW-1:0] queue_wa, queue_ra, queue_wd, queue_q;

  nbuf_ent_t     nbuf_mem [MAX_VERTICES];
  logic          nbuf_we;
  logic [VW-1:0] nbuf_wa, nbuf_ra;
  nbuf_ent_t     nbuf_wd, nbuf_q;

  logic [VW-1:0] nidx_mem [MAX_VERTICES];
  logic          nidx_we;
  logic [VW-1:0] nidx_wa, nidx_ra, nidx_wd, nidx_q;

  logic [NW-1:0] rkey_mem [MAX_EDGES];
  logic [VW-1:0] ckey_mem [MAX_EDGES];
  logic          key_we;
  logic [EW-1:0] key_wa, rkey_ra, ckey_ra;
  logic [NW-1:0] rkey_q;
  logic [VW-1:0] ckey_q;

  logic [CW-1:0] bc_mem [MAX_VERTICES + 1];
  logic [CW-1:0] br_mem [MAX_VERTICES + 1];
  logic          bc_we, br_we;
  logic [BW-1:0] bc_wa, bc_ra, br_wa, br_ra;
  logic [CW-1:0] bc_wd, br_wd, bc_q, br_q;

  logic [EW-1:0] sortb_mem [MAX_EDGES];
  logic          sortb_we;
  logic [EW-1:0] sortb_wa, sortb_ra, sortb_wd, sortb_q;

  logic [EW-1:0] epos_mem [MAX_EDGES];
  logic          epos_we;
  logic [EW-1:0] epos_wa, epos_ra, epos_wd, epos_q;

  always_ff @(posedge clk) begin
    if (e_we) begin
      erow_mem[e_wa] <= row;
      ecol_mem[e_wa] <= col;
    end
    erow_q <= erow_mem[e_ra];
    ecol_q <= ecol_mem[e_ra];
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    deg_q <= deg_mem[deg_ra];
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_q <= vis_mem[vis_ra];
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    queue_q <= queue_mem[queue_ra];
    if (nbuf_we) nbuf_mem[nbuf_wa] <= nbuf_wd;
    nbuf_q <= nbuf_mem[nbuf_ra];
    if (nidx_we) nidx_mem[nidx_wa] <= nidx_wd;
    nidx_q <= nidx_mem[nidx_ra];
    if (key_we) begin
      rkey_mem[key_wa] <= rk;
      ckey_mem[key_wa] <= ck;
    end
    rkey_q <= rkey_mem[rkey_ra];
    ckey_q <= ckey_mem[ckey_ra];
    if (bc_we) bc_mem[bc_wa] <= bc_wd;
    bc_q <= bc_mem[bc_ra];
    if (br_we) br_mem[br_wa] <= br_wd;
    br_q <= br_mem[br_ra];
    if (sortb_we) sortb_mem[sortb_wa] <= sortb_wd;
    sortb_q <= sortb_mem[sortb_ra];
    if (epos_we) epos_mem[epos_wa] <= epos_wd;
    epos_q <= epos_mem[epos_ra];
  end

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign accept    = start && !busy;

  always_comb begin
    if (nv == '0) begin
      n_cur = NW'(1);
    end else if (32'(nv) > MAX_VERTICES) begin
      n_cur = NW'(MAX_VERTICES);
    end else begin
      n_cur = NW'(nv);
    end
  end

  assign in_rng = (32'(erow_q) < 32'(n)) && (32'(ecol_q) < 32'(n));
  assign ediff  = (erow_q > ecol_q) ? (erow_q - ecol_q) : (ecol_q - erow_q);
  assign kdiff  = (rk > NW'(nidx_q)) ? (rk - NW'(nidx_q)) : (NW'(nidx_q) - rk);

  // Memory port control. The sequencer finishes each read-modify-write before it issues
  // the next read, so no entry is read while a write to it is still pending.
  always_comb begin
    e_we = 1'b0;        e_wa = '0;       e_ra = i[EW-1:0];
    deg_we = 1'b0;      deg_wa = '0;     deg_wd = '0;     deg_ra = '0;
    vis_we = 1'b0;      vis_wa = '0;     vis_wd = 1'b0;   vis_ra = '0;
    queue_we = 1'b0;    queue_wa = '0;   queue_wd = '0;   queue_ra = '0;
    nbuf_we = 1'b0;     nbuf_wa = '0;    nbuf_wd = '0;    nbuf_ra = '0;
    nidx_we = 1'b0;     nidx_wa = '0;    nidx_wd = '0;    nidx_ra = '0;
    key_we = 1'b0;      key_wa = i[EW-1:0];
    rkey_ra = '0;       ckey_ra = i[EW-1:0];
    bc_we = 1'b0;       bc_wa = '0;      bc_wd = '0;      bc_ra = '0;
    br_we = 1'b0;       br_wa = '0;      br_wd = '0;      br_ra = '0;
    sortb_we = 1'b0;    sortb_wa = '0;   sortb_wd = '0;   sortb_ra = i[EW-1:0];
    epos_we = 1'b0;     epos_wa = '0;    epos_wd = '0;    epos_ra = '0;
    case (state)
      S_IDLE: begin
        e_wa    = ecount[EW-1:0];
        e_we    = accept && (kind == KIND_LOAD) && (32'(ecount) < MAX_EDGES);
        nidx_ra = VW'(index);
        epos_ra = EW'(index);
      end
      S_CLR: begin
        deg_we = (32'(v) < 32'(n));
        deg_wa = VW'(v);
        vis_we = (32'(v) < 32'(n));
        vis_wa = VW'(v);
        bc_we  = 1'b1;
        bc_wa  = BW'(v);
        br_we  = 1'b1;
        br_wa  = BW'(v);
      end
      S_DEG_EV: deg_ra = VW'(erow_q);
      S_DEG_WR: begin
        deg_we = 1'b1;
        deg_wa = VW'(er);
        deg_wd = deg_q + 1'b1;
      end
      S_SEL_RD: begin
        deg_ra = VW'(v);
        vis_ra = VW'(v);
      end
      S_SEL_END: begin
        vis_we   = sfound;
        vis_wa   = s;
        vis_wd   = 1'b1;
        queue_we = sfound;
        queue_wa = VW'(tail);
        queue_wd = s;
        nidx_we  = sfound;
        nidx_wa  = s;
        nidx_wd  = VW'(n - 1'b1 - tail);
      end
      S_BFS_HEAD: queue_ra = VW'(head);
      S_SCAN_EV: begin
        vis_ra = VW'(ecol_q);
        deg_ra = VW'(ecol_q);
      end
      S_SCAN_VIS: begin
        vis_we = !vis_q;
        vis_wa = cn;
        vis_wd = 1'b1;
      end
      S_INS_CHK: begin
        nbuf_we = (j == '0);
        nbuf_wa = '0;
        nbuf_wd = '{deg: nd, vtx: cn};
        nbuf_ra = j - 1'b1;
      end
      S_INS_EV: begin
        nbuf_we = 1'b1;
        nbuf_wa = j;
        nbuf_wd = (nbuf_q.deg > nd) ? nbuf_q : nbuf_ent_t'{deg: nd, vtx: cn};
      end
      S_APP: nbuf_ra = VW'(v);
      S_APP_WR: begin
        queue_we = 1'b1;
        queue_wa = VW'(tail);
        queue_wd = nbuf_q.vtx;
        nidx_we  = 1'b1;
        nidx_wa  = nbuf_q.vtx;
        nidx_wd  = VW'(n - 1'b1 - tail);
      end
      S_KEY_EV: nidx_ra = VW'(erow_q);
      S_KEY_C:  nidx_ra = VW'(ec);
      S_KEY_WR: begin
        key_we = 1'b1;
        bc_ra  = BW'(ck);
        br_ra  = BW'(rk);
      end
      S_KEY_CNT: begin
        bc_we = 1'b1;
        bc_wa = BW'(ck);
        bc_wd = bc_q + 1'b1;
        br_we = 1'b1;
        br_wa = BW'(rk);
        br_wd = br_q + 1'b1;
      end
      S_PFX: begin
        bc_ra = BW'(v);
        br_ra = BW'(v);
      end
      S_PFX_WR: begin
        bc_we = 1'b1;
        bc_wa = BW'(v);
        bc_wd = accc;
        br_we = 1'b1;
        br_wa = BW'(v);
        br_wd = accr;
      end
      S_S1_B: bc_ra = BW'(ckey_q);
      S_S1_WR: begin
        sortb_we = 1'b1;
        sortb_wa = bc_q[EW-1:0];
        sortb_wd = i[EW-1:0];
        bc_we    = 1'b1;
        bc_wa    = BW'(ck);
        bc_wd    = bc_q + 1'b1;
      end
      S_S2_B: rkey_ra = sortb_q;
      S_S2_C: br_ra = BW'(rkey_q);
      S_S2_WR: begin
        epos_we = 1'b1;
        epos_wa = ee;
        epos_wd = br_q[EW-1:0];
        br_we   = 1'b1;
        br_wa   = BW'(rk);
        br_wd   = br_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ecount     <= '0;
      ordered    <= 1'b0;
      bw_before_r <= '0;
      bw_after_r <= '0;
      nv         <= NV_RESET;
      done_r     <= 1'b0;
      src        <= SRC_REG;
    end else begin
      done_r <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            nv      <= cfg_data;
            ordered <= 1'b0;
          end
          if (start) begin
            done_r   <= 1'b1;
            status_r <= ST_OK;
            value_r  <= '0;
            src      <= SRC_REG;
            case (kind)
              KIND_LOAD: begin
                if (32'(ecount) >= MAX_EDGES) begin
                  status_r <= ST_FULL;
                end else begin
                  value_r <= VAL_W'(ecount);
                  ecount  <= ecount + 1'b1;
                  ordered <= 1'b0;
                end
              end
              KIND_RUN: begin
                done_r <= 1'b0;
                n      <= n_cur;
                v      <= '0;
                head   <= '0;
                tail   <= '0;
                state  <= S_CLR;
              end
              KIND_RD_VTX: begin
                if (!ordered) status_r <= ST_NORD;
                else if (32'(index) >= 32'(n_cur)) status_r <= ST_RANGE;
                else src <= SRC_NIDX;
              end
              KIND_RD_EDG: begin
                if (!ordered) status_r <= ST_NORD;
                else if (32'(index) >= 32'(ecount)) status_r <= ST_RANGE;
                else src <= SRC_EPOS;
              end
              KIND_CLEAR: begin
                ecount      <= '0;
                ordered     <= 1'b0;
                bw_before_r <= '0;
                bw_after_r  <= '0;
              end
              default: ;
            endcase
          end
        end
        S_CLR: begin
          if (32'(v) == 32'(n)) begin
            i     <= '0;
            bwb   <= '0;
            state <= S_DEG_RD;
          end else begin
            v <= v + 1'b1;
          end
        end
        S_DEG_RD: state <= (i == ecount) ? S_SEL_INIT : S_DEG_EV;
        S_DEG_EV: begin
          er <= erow_q;
          if (in_rng) begin
            if (32'(ediff) > 32'(bwb)) bwb <= NW'(ediff);
            state <= S_DEG_WR;
          end else begin
            i     <= i + 1'b1;
            state <= S_DEG_RD;
          end
        end
        S_DEG_WR: begin
          i     <= i + 1'b1;
          state <= S_DEG_RD;
        end
        S_SEL_INIT: begin
          if (tail >= n) begin
            i     <= '0;
            bwa   <= '0;
            state <= S_KEY_RD;
          end else begin
            v      <= '0;
            sfound <= 1'b0;
            state  <= S_SEL_RD;
          end
        end
        S_SEL_RD: state <= (32'(v) == 32'(n)) ? S_SEL_END : S_SEL_EV;
        S_SEL_EV: begin
          if (!vis_q && (!sfound || deg_q < sdeg)) begin
            s      <= VW'(v);
            sdeg   <= deg_q;
            sfound <= 1'b1;
          end
          v     <= v + 1'b1;
          state <= S_SEL_RD;
        end
        S_SEL_END: begin
          if (!sfound) begin
            i     <= '0;
            bwa   <= '0;
            state <= S_KEY_RD;
          end else begin
            tail  <= tail + 1'b1;
            state <= S_BFS_HEAD;
          end
        end
        S_BFS_HEAD: begin
          if (head == tail) begin
            state <= S_SEL_INIT;
          end else begin
            head  <= head + 1'b1;
            state <= S_BFS_Y;
          end
        end
        S_BFS_Y: begin
          y     <= queue_q;
          i     <= '0;
          k     <= '0;
          state <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          if (i == ecount) begin
            v     <= '0;
            state <= S_APP;
          end else begin
            state <= S_SCAN_EV;
          end
        end
        S_SCAN_EV: begin
          i  <= i + 1'b1;
          cn <= VW'(ecol_q);
          if ((32'(erow_q) == 32'(y)) && (32'(ecol_q) < 32'(n)) && (erow_q != ecol_q)
              && (k < n)) begin
            state <= S_SCAN_VIS;
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_VIS: begin
          if (vis_q) begin
            state <= S_SCAN_RD;
          end else begin
            nd    <= deg_q;
            j     <= VW'(k);
            k     <= k + 1'b1;
            state <= S_INS_CHK;
          end
        end
        S_INS_CHK: state <= (j == '0) ? S_SCAN_RD : S_INS_EV;
        S_INS_EV: begin
          // Entries of higher degree move up one slot; equal degree keeps edge order.
          if (nbuf_q.deg > nd) begin
            j     <= j - 1'b1;
            state <= S_INS_CHK;
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_APP: begin
          if ((32'(v) == 32'(k)) || (tail >= n)) state <= S_BFS_HEAD;
          else state <= S_APP_WR;
        end
        S_APP_WR: begin
          tail  <= tail + 1'b1;
          v     <= v + 1'b1;
          state <= S_APP;
        end
        S_KEY_RD: begin
          if (i == ecount) begin
            v     <= '0;
            accc  <= '0;
            accr  <= '0;
            state <= S_PFX;
          end else begin
            state <= S_KEY_EV;
          end
        end
        S_KEY_EV: begin
          ec <= ecol_q;
          if (in_rng) begin
            state <= S_KEY_C;
          end else begin
            // Entries outside the matrix sort after all others.
            rk    <= n;
            ck    <= '0;
            state <= S_KEY_WR;
          end
        end
        S_KEY_C: begin
          rk    <= NW'(nidx_q);
          state <= S_KEY_D;
        end
        S_KEY_D: begin
          ck <= nidx_q;
          if (kdiff > bwa) bwa <= kdiff;
          state <= S_KEY_WR;
        end
        S_KEY_WR: state <= S_KEY_CNT;
        S_KEY_CNT: begin
          i     <= i + 1'b1;
          state <= S_KEY_RD;
        end
        S_PFX: begin
          if (32'(v) == 32'(n) + 1) begin
            i     <= '0;
            state <= S_S1_RD;
          end else begin
            state <= S_PFX_WR;
          end
        end
        S_PFX_WR: begin
          accc  <= accc + bc_q;
          accr  <= accr + br_q;
          v     <= v + 1'b1;
          state <= S_PFX;
        end
        S_S1_RD: begin
          if (i == ecount) begin
            i     <= '0;
            state <= S_S2_RD;
          end else begin
            state <= S_S1_B;
          end
        end
        S_S1_B: begin
          ck    <= ckey_q;
          state <= S_S1_WR;
        end
        S_S1_WR: begin
          i     <= i + 1'b1;
          state <= S_S1_RD;
        end
        S_S2_RD: state <= (i == ecount) ? S_DONE : S_S2_B;
        S_S2_B: begin
          ee    <= sortb_q;
          state <= S_S2_C;
        end
        S_S2_C: begin
          rk    <= rkey_q;
          state <= S_S2_WR;
        end
        S_S2_WR: begin
          i     <= i + 1'b1;
          state <= S_S2_RD;
        end
        S_DONE: begin
          bw_before_r <= (32'(bwb) > 32'(BWID_MAX)) ? BWID_MAX : BWID_W'(bwb);
          bw_after_r  <= (32'(bwa) > 32'(BWID_MAX)) ? BWID_MAX : BWID_W'(bwa);
          ordered  <= 1'b1;
          done_r   <= 1'b1;
          status_r <= ST_OK;
          value_r  <= '0;
          src      <= SRC_REG;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign done             = done_r;
  assign status           = status_r;
  assign value            = (src == SRC_NIDX) ? VAL_W'(nidx_q) :
                            (src == SRC_EPOS) ? VAL_W'(epos_q) : value_r;
  assign bandwidth_before = bw_before_r;
  assign bandwidth_after  = bw_after_r;

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept) || $past(state == S_DONE))
    else $error("result word without a command or run completion");

  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_CLR) |-> (head <= tail) && (tail <= n))
    else $error("queue pointers out of order");

  a_edge_bound: assert property (@(posedge clk) disable iff (rst)
    32'(ecount) <= MAX_EDGES)
    else $error("edge count beyond store depth");

  a_run_quiet: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_DONE) |=> !done)
    else $error("result word during a run");

endmodule
